/* hw/rtl/veb_pkg.sv */
// ----------------------------------------------------------------------------
// veb_pkg
// Shared constants, codes and the memory request bundle of the key set.
// ----------------------------------------------------------------------------
package veb_pkg;

    localparam int UNIV_BITS = 16;
    localparam int KEY_W     = UNIV_BITS;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int LEAF_AW   = UNIV_BITS - BIT_W;
    localparam int MID_AW    = UNIV_BITS - 2 * BIT_W;
    localparam int TOP_W     = 1 << MID_AW;
    localparam int TOP_IW    = MID_AW;
    localparam int LEAF_WORDS = 1 << LEAF_AW;
    localparam int MID_WORDS  = 1 << MID_AW;
    localparam int NSEL_W    = 5;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_SUCC   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [NSEL_W-1:0] N_RESET = 5'd16;
    localparam logic [NSEL_W-1:0] N_MIN   = 5'd1;
    localparam logic [NSEL_W-1:0] N_MAX   = 5'd16;

    typedef struct packed {
        logic                 leaf_rd;
        logic                 leaf_wr;
        logic [LEAF_AW-1:0]   leaf_addr;
        logic [WORD_W-1:0]    leaf_wdata;
        logic                 mid_rd;
        logic                 mid_wr;
        logic [MID_AW-1:0]    mid_addr;
        logic [WORD_W-1:0]    mid_wdata;
        logic                 top_wr;
        logic [TOP_W-1:0]     top_wdata;
    } mem_req_t;

endpackage

/* hw/rtl/veb_regs.sv */
// ----------------------------------------------------------------------------
// veb_regs
// APB register port holding universe_log2; gives the clamped universe_log2.
// ----------------------------------------------------------------------------
module veb_regs
    import veb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [NSEL_W-1:0] n_eff
);

    localparam logic [2:0] ADDR_ULOG2 = 3'd0;

    logic [NSEL_W-1:0] n_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_ULOG2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= N_RESET;
        end
        else if (wr_en)
        begin
            n_reg <= pwdata[NSEL_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_ULOG2) ? {{(32 - NSEL_W){1'b0}}, n_reg} : 32'd0;

    always_comb
    begin
        if (n_reg < N_MIN)
        begin
            n_eff = N_MIN;
        end
        else if (n_reg > N_MAX)
        begin
            n_eff = N_MAX;
        end
        else
        begin
            n_eff = n_reg;
        end
    end

endmodule

/* hw/rtl/veb_store.sv */
// ----------------------------------------------------------------------------
// veb_store
// Leaf and middle bitmap memories (registered read), top bitmap
// register, and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module veb_store
    import veb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic              busy,
    output logic [WORD_W-1:0] leaf_q,
    output logic [WORD_W-1:0] mid_q,
    output logic [TOP_W-1:0]  top_q
);

    logic [WORD_W-1:0]  leaf_mem [LEAF_WORDS];
    logic [WORD_W-1:0]  mid_mem  [MID_WORDS];
    logic [WORD_W-1:0]  leaf_q_reg;
    logic [WORD_W-1:0]  mid_q_reg;
    logic [TOP_W-1:0]   top_reg;
    logic [LEAF_AW-1:0] clr_reg;
    logic               busy_reg;
    logic               clr_mid;

    assign clr_mid = (clr_reg[LEAF_AW-1:MID_AW] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
            top_reg  <= '0;
        end
        else if (busy_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (&clr_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (req.top_wr)
        begin
            top_reg <= req.top_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            leaf_mem[clr_reg] <= '0;
        end
        else if (req.leaf_wr)
        begin
            leaf_mem[req.leaf_addr] <= req.leaf_wdata;
        end
        if (!busy_reg && req.leaf_rd)
        begin
            leaf_q_reg <= leaf_mem[req.leaf_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (clr_mid)
            begin
                mid_mem[clr_reg[MID_AW-1:0]] <= '0;
            end
        end
        else if (req.mid_wr)
        begin
            mid_mem[req.mid_addr] <= req.mid_wdata;
        end
        if (!busy_reg && req.mid_rd)
        begin
            mid_q_reg <= mid_mem[req.mid_addr];
        end
    end

    assign busy   = busy_reg;
    assign leaf_q = leaf_q_reg;
    assign mid_q  = mid_q_reg;
    assign top_q  = top_reg;

endmodule

/* hw/rtl/veb_ctrl.sv */
// ----------------------------------------------------------------------------
// veb_ctrl
// Request sequencer: insert read-modify-write and the successor walk over
// leaf, middle and top bitmaps.
// ----------------------------------------------------------------------------
module veb_ctrl
    import veb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic signed [16:0] search_key,
    input  logic [NSEL_W-1:0] n_eff,
    input  logic              store_busy,
    input  logic [WORD_W-1:0] leaf_q,
    input  logic [WORD_W-1:0] mid_q,
    input  logic [TOP_W-1:0]  top_q,
    output mem_req_t          req,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [1:0]        res_status,
    output logic [KEY_W-1:0]  res_key
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_QLEAF,
        S_QMID,
        S_QMID2,
        S_QLEAF2,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [KEY_W-1:0]   s_reg, s_next;
    logic [LEAF_AW-1:0] lf_reg, lf_next;
    logic [MID_AW-1:0]  mw_reg, mw_next;
    logic [1:0]         status_reg, status_next;
    logic [KEY_W-1:0]   found_reg, found_next;

    logic [16:0]        qs;
    logic               ins_bad;
    logic               qry_bad;
    logic [WORD_W-1:0]  leaf_m;
    logic [WORD_W-1:0]  mid_m;
    logic [TOP_W-1:0]   top_m;
    logic [LEAF_AW:0]   nl;
    logic [MID_AW:0]    nm;
    logic [KEY_W-1:0]   cand;

    function automatic logic [BIT_W-1:0] low_word(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = i[BIT_W-1:0];
            end
        end
        return idx;
    endfunction

    function automatic logic [TOP_IW-1:0] low_top(input logic [TOP_W-1:0] x);
        logic [TOP_IW-1:0] idx;
        idx = '0;
        for (int i = TOP_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = i[TOP_IW-1:0];
            end
        end
        return idx;
    endfunction

    assign qs      = $unsigned(search_key) + 17'd1;
    assign ins_bad = search_key[16] || (({1'b0, search_key[KEY_W-1:0]} >> n_eff) != '0);
    assign qry_bad = (search_key[16] && !(&search_key)) || ((qs >> n_eff) != '0);
    assign leaf_m  = leaf_q & ({WORD_W{1'b1}} << s_reg[BIT_W-1:0]);
    assign mid_m   = mid_q & ({WORD_W{1'b1}} << lf_reg[BIT_W-1:0]);
    assign nl      = {1'b0, s_reg[KEY_W-1:BIT_W]} + 1'b1;
    assign nm      = {1'b0, lf_reg[LEAF_AW-1:BIT_W]} + 1'b1;
    assign top_m   = top_q & ({TOP_W{1'b1}} << nm[MID_AW-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        lf_next     = lf_reg;
        mw_next     = mw_reg;
        status_next = status_reg;
        found_next  = found_reg;
        req         = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        cand        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !store_busy;
                if (in_valid && in_ready)
                begin
                    status_next = ST_OK;
                    found_next  = '0;
                    s_next      = search_key[KEY_W-1:0];
                    if (opcode == OP_INSERT)
                    begin
                        if (ins_bad)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            req.leaf_rd   = 1'b1;
                            req.leaf_addr = search_key[KEY_W-1:BIT_W];
                            req.mid_rd    = 1'b1;
                            req.mid_addr  = search_key[KEY_W-1:2*BIT_W];
                            state_next    = S_INS;
                        end
                    end
                    else
                    begin
                        s_next = qs[KEY_W-1:0];
                        if (qry_bad)
                        begin
                            status_next = ST_NONE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            req.leaf_rd   = 1'b1;
                            req.leaf_addr = qs[KEY_W-1:BIT_W];
                            state_next    = S_QLEAF;
                        end
                    end
                end
            end

            S_INS:
            begin
                req.leaf_wr    = 1'b1;
                req.leaf_addr  = s_reg[KEY_W-1:BIT_W];
                req.leaf_wdata = leaf_q | ({{(WORD_W-1){1'b0}}, 1'b1} << s_reg[BIT_W-1:0]);
                req.mid_wr     = 1'b1;
                req.mid_addr   = s_reg[KEY_W-1:2*BIT_W];
                req.mid_wdata  = mid_q
                               | ({{(WORD_W-1){1'b0}}, 1'b1} << s_reg[2*BIT_W-1:BIT_W]);
                req.top_wr     = 1'b1;
                req.top_wdata  = top_q
                               | ({{(TOP_W-1){1'b0}}, 1'b1} << s_reg[KEY_W-1:2*BIT_W]);
                state_next     = S_DONE;
            end

            S_QLEAF:
            begin
                state_next = S_DONE;
                if (leaf_m != '0)
                begin
                    cand = {s_reg[KEY_W-1:BIT_W], low_word(leaf_m)};
                    if (({1'b0, cand} >> n_eff) == '0)
                    begin
                        found_next = cand;
                    end
                    else
                    begin
                        status_next = ST_NONE;
                    end
                end
                else if (nl[LEAF_AW])
                begin
                    status_next = ST_NONE;
                end
                else
                begin
                    req.mid_rd   = 1'b1;
                    req.mid_addr = nl[LEAF_AW-1:BIT_W];
                    lf_next      = nl[LEAF_AW-1:0];
                    state_next   = S_QMID;
                end
            end

            S_QMID:
            begin
                if (mid_m != '0)
                begin
                    lf_next       = {lf_reg[LEAF_AW-1:BIT_W], low_word(mid_m)};
                    req.leaf_rd   = 1'b1;
                    req.leaf_addr = lf_next;
                    state_next    = S_QLEAF2;
                end
                else if (nm[MID_AW] || (top_m == '0))
                begin
                    status_next = ST_NONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    mw_next      = low_top(top_m);
                    req.mid_rd   = 1'b1;
                    req.mid_addr = mw_next;
                    state_next   = S_QMID2;
                end
            end

            S_QMID2:
            begin
                if (mid_q == '0)
                begin
                    status_next = ST_NONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    lf_next       = {mw_reg, low_word(mid_q)};
                    req.leaf_rd   = 1'b1;
                    req.leaf_addr = lf_next;
                    state_next    = S_QLEAF2;
                end
            end

            S_QLEAF2:
            begin
                state_next = S_DONE;
                cand       = {lf_reg, low_word(leaf_q)};
                if ((leaf_q != '0) && (({1'b0, cand} >> n_eff) == '0))
                begin
                    found_next = cand;
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            s_reg      <= '0;
            lf_reg     <= '0;
            mw_reg     <= '0;
            status_reg <= ST_OK;
            found_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            s_reg      <= s_next;
            lf_reg     <= lf_next;
            mw_reg     <= mw_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    assign res_status = status_reg;
    assign res_key    = found_reg;

endmodule

/* hw/rtl/van_emde_boas_insert_successor_top.sv */
// ----------------------------------------------------------------------------
// van_emde_boas_insert_successor_top
// Integer key set over a universe of 2^n keys with insert and successor
// query. Keys are held as a three-level bitmap: a 1024 x 64 leaf memory,
// a 16 x 64 middle memory and a 16-bit top register. Items are handled
// one at a time. An insert reads the leaf and middle words, then writes
// them back together with the top register before its result is passed on.
// A query walks a chain of dependent memory reads: leaf word, middle word,
// then a middle word picked through the top bitmap, then the leaf word it
// points to, each read registered, and stops once the answer is known. A
// key out of range needs no memory access: the controller goes straight to
// its result. While the output register is full and out_ready is low, the
// controller holds its result and accepts nothing. After reset a clearing
// pass zeroes the memories; in_ready stays low during it while register
// writes are still taken. A result may wait in the output register while
// the next item is processed.
// ----------------------------------------------------------------------------
module van_emde_boas_insert_successor_top
    import veb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [16:0] search_key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [15:0]        found_key,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [NSEL_W-1:0] n_eff;
    mem_req_t          req;
    logic              store_busy;
    logic [WORD_W-1:0] leaf_q;
    logic [WORD_W-1:0] mid_q;
    logic [TOP_W-1:0]  top_q;
    logic              res_valid;
    logic              res_ready;
    logic [1:0]        res_status;
    logic [KEY_W-1:0]  res_key;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [KEY_W-1:0]  found_reg;

    veb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .n_eff   (n_eff)
    );

    veb_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .busy   (store_busy),
        .leaf_q (leaf_q),
        .mid_q  (mid_q),
        .top_q  (top_q)
    );

    veb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .search_key (search_key),
        .n_eff      (n_eff),
        .store_busy (store_busy),
        .leaf_q     (leaf_q),
        .mid_q      (mid_q),
        .top_q      (top_q),
        .req        (req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_key    (res_key)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg <= res_status;
            found_reg  <= res_key;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found_key = found_reg;

    a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in progress");

    a_key_zero_unless_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (found_key == '0))
        else $error("found_key nonzero on a failed item");

    a_no_mem_access_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !(req.leaf_rd || req.leaf_wr || req.mid_rd || req.mid_wr))
        else $error("memory access issued during clearing pass");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the integer key set against a bitmap copy of the set that the bench
// keeps itself. Inserts and successor queries go in through a valid/ready
// channel with random bursts and gaps. Results are drained under a changing
// ready pattern and compared in order. The universe size is changed over
// APB between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
    import veb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNIVERSE_LOG2 = 3'd0;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_key;
    } response_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               opcode = OP_INSERT;
    logic signed [16:0] search_key = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [15:0]        found_key;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [WORD_W-1:0]     shadow_words [LEAF_WORDS];
    logic [LEAF_WORDS-1:0] shadow_used = '0;
    logic [NSEL_W-1:0]     shadow_universe = N_RESET;

    response_t pending_responses [$];
    int        stored_list [$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        ready_mode = 0;
    int        ready_chunk = 0;

    van_emde_boas_insert_successor_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .search_key (search_key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_key  (found_key),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 clk = ~clk;

    initial
    begin
        for (int i = 0; i < LEAF_WORDS; i++)
        begin
            shadow_words[i] = '0;
        end
    end

    function automatic int active_width();
        int n;
        n = shadow_universe;
        if (n < int'(N_MIN))
            n = N_MIN;
        if (n > int'(N_MAX))
            n = N_MAX;
        return n;
    endfunction

    // smallest stored key at or above start, -1 if none
    function automatic int lowest_stored_from(input int start);
        int w;
        int b;
        w = start >> 6;
        for (b = start & 63; b < WORD_W; b++)
            if (shadow_words[w][b])
                return w * WORD_W + b;
        for (w = w + 1; w < LEAF_WORDS; w++)
        begin
            if (shadow_used[w])
            begin
                for (b = 0; b < WORD_W; b++)
                    if (shadow_words[w][b])
                        return w * WORD_W + b;
            end
        end
        return -1;
    endfunction

    function automatic response_t apply_request(input logic op, input logic signed [16:0] key);
        response_t r;
        int k;
        int limit;
        int hit;
        r.status = ST_OK;
        r.found_key = '0;
        k = key;
        limit = 1 << active_width();
        if (op == OP_INSERT)
        begin
            if (k < 0 || k >= limit)
                r.status = ST_RANGE;
            else
            begin
                shadow_words[k >> 6][k & 63] = 1'b1;
                shadow_used[k >> 6] = 1'b1;
            end
        end
        else if (k < -1 || k + 1 >= limit)
            r.status = ST_NONE;
        else
        begin
            hit = lowest_stored_from(k + 1);
            if (hit < 0 || hit >= limit)
                r.status = ST_NONE;
            else
                r.found_key = hit[15:0];
        end
        return r;
    endfunction

    task automatic send_item(input logic op, input int key);
        int gap;
        int pick;
        logic signed [16:0] key_bits;
        response_t want;
        key_bits = key[16:0];
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(4, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        search_key <= key_bits;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = apply_request(op, key_bits);
        pending_responses.push_back(want);
        if (op == OP_INSERT && want.status == ST_OK)
            stored_list.push_back(key);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_universe(input int setting);
        wait_drained();
        write_register(REG_UNIVERSE_LOG2, setting);
        shadow_universe = setting[NSEL_W-1:0];
    endtask

    task automatic test_full_universe_edges();
        send_item(OP_SUCC, -1);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, 65535);
        send_item(OP_INSERT, -1);
        send_item(OP_INSERT, -65536);
        send_item(OP_INSERT, 0);
        send_item(OP_SUCC, -1);
        send_item(OP_SUCC, 0);
        send_item(OP_SUCC, 65534);
        send_item(OP_SUCC, 65535);
        send_item(OP_SUCC, -2);
        send_item(OP_SUCC, -65536);
        send_item(OP_INSERT, 1000);
        send_item(OP_SUCC, 999);
    endtask

    task automatic test_smallest_universe();
        set_universe(1);
        send_item(OP_INSERT, 1);
        send_item(OP_INSERT, 2);
        send_item(OP_SUCC, -1);
        send_item(OP_SUCC, 0);
        send_item(OP_SUCC, 1);
        // zero behaves as one
        set_universe(0);
        send_item(OP_SUCC, 0);
        send_item(OP_INSERT, 3);
    endtask

    // keys stored above a lowered universe must stay hidden
    task automatic test_shrunk_universe();
        set_universe(4);
        send_item(OP_SUCC, 1);
        send_item(OP_INSERT, 15);
        send_item(OP_SUCC, 1);
        set_universe(31);
        send_item(OP_SUCC, 15);
    endtask

    task automatic random_phase(input int setting, input int count);
        int limit;
        int pick;
        int key;
        set_universe(setting);
        limit = 1 << active_width();
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_item(OP_INSERT, $urandom_range(0, limit - 1));
            else if (pick < 80)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    key = -1;
                else if (pick < 13 && stored_list.size() > 0)
                begin
                    key = stored_list[$urandom_range(0, stored_list.size() - 1)];
                    key = key + $urandom_range(0, 4) - 2;
                    if (key > 65535)
                        key = 65535;
                    if (key < -1)
                        key = -1;
                end
                else
                    key = $urandom_range(0, limit) - 1;
                send_item(OP_SUCC, key);
            end
            else if (pick < 90)
                send_item(OP_INSERT, $urandom_range(0, 131071));
            else
                send_item(OP_SUCC, $urandom_range(0, 131071));
        end
    endtask

    task automatic test_random_traffic();
        int settings [8] = '{16, 2, 9, 0, 16, 5, 31, 12};
        for (int p = 0; p < 8; p++)
            random_phase(settings[p], 185);
        random_phase($urandom_range(0, 31), 45);
    endtask

    always @(negedge clk)
    begin
        if (ready_chunk == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_chunk = $urandom_range(16, 160);
        end
        ready_chunk = ready_chunk - 1;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        response_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: result with no item pending: status %0d found_key %0d",
                         $time, status, found_key);
                errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (found_key !== want.found_key)
                begin
                    $display("%0t: found_key mismatch: expected %0d actual %0d",
                             $time, want.found_key, found_key);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results pending",
                     $time, idle_cycles, pending_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_full_universe_edges();
        test_smallest_universe();
        test_shrunk_universe();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/veb_pkg.sv
hw/rtl/veb_regs.sv
hw/rtl/veb_store.sv
hw/rtl/veb_ctrl.sv
hw/rtl/van_emde_boas_insert_successor_top.sv
bench/testbench.sv
